[hdl/stl_pkg.sv]
// Package for the script token lexer: item types, mode codes, token kinds
// and keyword lookup. No dependencies.
`timescale 1ns / 1ps
package stl_pkg;

  localparam int LINE_WIDTH        = 24;
  localparam int COLUMN_WIDTH      = 16;
  localparam int KEYWORD_MAX_CHARS = 8;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } src_item_t;

  typedef struct packed {
    logic [5:0]              token_kind;
    logic [LINE_WIDTH-1:0]   token_line;
    logic [COLUMN_WIDTH-1:0] token_column;
    logic [15:0]             token_length;
    logic [62:0]             num_value;
    logic                    int_overflow;
    logic                    true_flag;
    logic [7:0]              string_byte;
    logic                    last_of_run;
  } tok_item_t;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_NUMDOT, M_FRAC, M_IDENT, M_DIR, M_STR, M_SLASH,
    M_LCOM, M_BCOM, M_OP
  } lex_mode_t;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [5:0] K_END = 6'd0, K_INT = 6'd1, K_FRAC = 6'd2,
    K_STR = 6'd3, K_IDENT = 6'd4, K_DIR = 6'd5, K_IF = 6'd6, K_ELSE = 6'd7,
    K_WHILE = 6'd8, K_FOR = 6'd9, K_FOREACH = 6'd10, K_REPEAT = 6'd11,
    K_UNTIL = 6'd12, K_FUNCTION = 6'd13, K_RETURN = 6'd14, K_BREAK = 6'd15,
    K_CONTINUE = 6'd16, K_TRY = 6'd17, K_CATCH = 6'd18, K_FINALLY = 6'd19,
    K_IN = 6'd20, K_TRUE = 6'd21, K_FALSE = 6'd22, K_NULL = 6'd23,
    K_LPAREN = 6'd24, K_RPAREN = 6'd25, K_LBRACE = 6'd26, K_RBRACE = 6'd27,
    K_LBRACK = 6'd28, K_RBRACK = 6'd29, K_COMMA = 6'd30, K_DOT = 6'd31,
    K_COLON = 6'd32, K_SEMI = 6'd33, K_PLUS = 6'd34, K_MINUS = 6'd35,
    K_STAR = 6'd36, K_PCT = 6'd37, K_NE = 6'd38, K_NOT = 6'd39,
    K_EQ = 6'd40, K_ASSIGN = 6'd41, K_LE = 6'd42, K_LT = 6'd43,
    K_GE = 6'd44, K_GT = 6'd45, K_AND = 6'd46, K_OR = 6'd47, K_DIV = 6'd48,
    K_BADCHAR = 6'd49, K_UNTERM = 6'd50, K_SCHAR = 6'd51;

  function automatic logic kw_hit(logic [63:0] w, logic [15:0] n,
                                  logic [63:0] t, logic [15:0] tn);
    return (w == t) && (n == tn);
  endfunction

  function automatic logic [5:0] kw_kind(logic [63:0] w, logic [15:0] n);
    logic [5:0] k;
    k = K_IDENT;
    if (kw_hit(w, n, 64'("if"), 16'd2))        k = K_IF;
    if (kw_hit(w, n, 64'("else"), 16'd4))      k = K_ELSE;
    if (kw_hit(w, n, 64'("while"), 16'd5))     k = K_WHILE;
    if (kw_hit(w, n, 64'("for"), 16'd3))       k = K_FOR;
    if (kw_hit(w, n, 64'("foreach"), 16'd7))   k = K_FOREACH;
    if (kw_hit(w, n, 64'("ForEach"), 16'd7))   k = K_FOREACH;
    if (kw_hit(w, n, 64'("repeat"), 16'd6))    k = K_REPEAT;
    if (kw_hit(w, n, 64'("until"), 16'd5))     k = K_UNTIL;
    if (kw_hit(w, n, 64'("function"), 16'd8))  k = K_FUNCTION;
    if (kw_hit(w, n, 64'("return"), 16'd6))    k = K_RETURN;
    if (kw_hit(w, n, 64'("break"), 16'd5))     k = K_BREAK;
    if (kw_hit(w, n, 64'("continue"), 16'd8))  k = K_CONTINUE;
    if (kw_hit(w, n, 64'("try"), 16'd3))       k = K_TRY;
    if (kw_hit(w, n, 64'("catch"), 16'd5))     k = K_CATCH;
    if (kw_hit(w, n, 64'("finally"), 16'd7))   k = K_FINALLY;
    if (kw_hit(w, n, 64'("in"), 16'd2))        k = K_IN;
    if (kw_hit(w, n, 64'("true"), 16'd4))      k = K_TRUE;
    if (kw_hit(w, n, 64'("false"), 16'd5))     k = K_FALSE;
    if (kw_hit(w, n, 64'("null"), 16'd4))      k = K_NULL;
    return k;
  endfunction

  function automatic tok_item_t mk_tok(logic [5:0] kind,
                                       logic [LINE_WIDTH-1:0] line,
                                       logic [COLUMN_WIDTH-1:0] col,
                                       logic [15:0] len);
    tok_item_t t;
    t = '0;
    t.token_kind   = kind;
    t.token_line   = line;
    t.token_column = col;
    t.token_length = len;
    return t;
  endfunction

  function automatic logic [15:0] len_inc(logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

endpackage

[hdl/script_token_lexer.sv]
// Script token lexer: one source byte per transfer in, tokens out.
// Results of a byte are registered and appear in the cycle after its transfer.
// Throughput: one byte per cycle while tok_stall is low; a byte that yields several
// results (up to 3) holds the input until its last result is taken from the buffer.
// Reset: synchronous; clears lexer state, positions and the result buffer.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module script_token_lexer import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  src_item_t src_data,
  output logic      tok_valid,
  input  logic      tok_stall,
  output tok_item_t tok_data
);

  localparam logic [LINE_WIDTH-1:0]   LINE_SAT = '1;
  localparam logic [COLUMN_WIDTH-1:0] COL_SAT  = '1;
  localparam logic [62:0]             VAL_SAT  = '1;

  lex_mode_t mode, mode_next;
  logic [7:0] held_char, held_char_next;
  logic held_dot, held_dot_next;
  logic [LINE_WIDTH-1:0] sline, sline_next, lcnt, lcnt_next;
  logic [COLUMN_WIDTH-1:0] scol, scol_next, ccnt, ccnt_next;
  logic [15:0] rlen, rlen_next;
  logic [62:0] acc, acc_next;
  logic ovf, ovf_next;
  logic [63:0] wbuf, wbuf_next;
  logic wlong, wlong_next;
  logic cq, cq_next;
  logic esc, esc_next;

  tok_item_t slot [3];
  tok_item_t res [3];
  logic [1:0] n, cnt, rd;

  logic in_xfer, out_xfer;
  assign out_xfer  = tok_valid && !tok_stall;
  assign src_stall = !((cnt == 2'd0) || (cnt == 2'd1 && out_xfer));
  assign in_xfer   = src_valid && !src_stall;
  assign tok_valid = (cnt != 2'd0);
  assign tok_data  = res[rd];

  logic [7:0] c;
  logic dig, alp, fin, do_begin;
  logic [66:0] mac;
  logic [5:0] k;
  logic [7:0] v;
  logic [COLUMN_WIDTH-1:0] dcol;
  tok_item_t t;

  always_comb begin
    c = src_data.ch;
    dig = (c >= "0") && (c <= "9");
    alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    mac = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {63'b0, c[3:0]};
    dcol = (ccnt == COL_SAT || ccnt < COLUMN_WIDTH'(2)) ? ccnt : ccnt - COLUMN_WIDTH'(1);
    k = K_IDENT;
    v = c;
    t = '0;
    for (int i = 0; i < 3; i++) slot[i] = '0;
    n = 2'd0;
    fin = 1'b0;
    do_begin = 1'b0;
    mode_next = mode; held_char_next = held_char; held_dot_next = held_dot;
    sline_next = sline; scol_next = scol; rlen_next = rlen;
    lcnt_next = lcnt; ccnt_next = ccnt; acc_next = acc; ovf_next = ovf;
    wbuf_next = wbuf; wlong_next = wlong; cq_next = cq; esc_next = esc;

    if (src_data.cmd == CMD_END) begin
      fin = 1'b1;
    end else begin
      unique case (mode)
        M_NUM: begin
          if (dig) begin
            rlen_next = len_inc(rlen);
            if (!ovf) begin
              if (mac[66:63] != 4'd0) begin
                ovf_next = 1'b1;
                acc_next = VAL_SAT;
              end else begin
                acc_next = mac[62:0];
              end
            end
          end else if (c == ".") begin
            mode_next = M_NUMDOT;
            held_dot_next = 1'b1;
          end else begin
            fin = 1'b1; do_begin = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (dig) begin
            mode_next = M_FRAC;
            held_dot_next = 1'b0;
            rlen_next = len_inc(len_inc(rlen));
          end else begin
            fin = 1'b1; do_begin = 1'b1;
          end
        end
        M_FRAC: begin
          if (dig) rlen_next = len_inc(rlen);
          else begin fin = 1'b1; do_begin = 1'b1; end
        end
        M_IDENT: begin
          if (alp || dig || c == "_") begin
            if (rlen >= 16'(KEYWORD_MAX_CHARS)) wlong_next = 1'b1;
            else wbuf_next = {wbuf[55:0], c};
            rlen_next = len_inc(rlen);
          end else begin
            fin = 1'b1; do_begin = 1'b1;
          end
        end
        M_DIR: begin
          if (alp) rlen_next = len_inc(rlen);
          else begin fin = 1'b1; do_begin = 1'b1; end
        end
        M_STR: begin
          rlen_next = len_inc(rlen);
          if (esc) begin
            if (c == "n") v = 8'd10;
            else if (c == "t") v = 8'd9;
            else if (c == "r") v = 8'd13;
            esc_next = 1'b0;
            t = mk_tok(K_SCHAR, sline, scol, 16'd0);
            t.string_byte = v;
            slot[n] = t; n = n + 2'd1;
          end else if (c == (cq ? "'" : "\"")) begin
            slot[n] = mk_tok(K_STR, sline, scol, len_inc(rlen)); n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (c == "\\") begin
            esc_next = 1'b1;
          end else begin
            t = mk_tok(K_SCHAR, sline, scol, 16'd0);
            t.string_byte = c;
            slot[n] = t; n = n + 2'd1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_next = M_LCOM;
          else if (c == "*") begin
            mode_next = M_BCOM; held_dot_next = 1'b0;
          end else begin
            fin = 1'b1; do_begin = 1'b1;
          end
        end
        M_LCOM: begin
          if (c == "\n") mode_next = M_IDLE;
        end
        M_BCOM: begin
          if (held_dot && c == "/") begin
            mode_next = M_IDLE; held_dot_next = 1'b0;
          end else begin
            held_dot_next = (c == "*");
          end
        end
        M_OP: begin
          k = K_END;
          if (c == "=") begin
            if (held_char == "!") k = K_NE;
            else if (held_char == "=") k = K_EQ;
            else if (held_char == "<") k = K_LE;
            else if (held_char == ">") k = K_GE;
          end else if (c == "&" && held_char == "&") k = K_AND;
          else if (c == "|" && held_char == "|") k = K_OR;
          if (k != K_END) begin
            slot[n] = mk_tok(k, sline, scol, 16'd2); n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            fin = 1'b1; do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase
    end

    // flush the pending token
    if (fin) begin
      unique case (mode)
        M_NUM, M_NUMDOT: begin
          t = mk_tok(K_INT, sline, scol, rlen);
          t.num_value = acc;
          t.int_overflow = ovf;
          slot[n] = t; n = n + 2'd1;
          if (mode == M_NUMDOT) begin
            slot[n] = mk_tok(K_DOT, lcnt, dcol, 16'd1); n = n + 2'd1;
          end
        end
        M_FRAC: begin slot[n] = mk_tok(K_FRAC, sline, scol, rlen); n = n + 2'd1; end
        M_IDENT: begin
          k = wlong ? K_IDENT : kw_kind(wbuf, rlen);
          t = mk_tok(k, sline, scol, rlen);
          t.true_flag = (k == K_TRUE);
          slot[n] = t; n = n + 2'd1;
        end
        M_DIR: begin slot[n] = mk_tok(K_DIR, sline, scol, rlen); n = n + 2'd1; end
        M_STR: begin slot[n] = mk_tok(K_UNTERM, sline, scol, rlen); n = n + 2'd1; end
        M_SLASH: begin slot[n] = mk_tok(K_DIV, sline, scol, 16'd1); n = n + 2'd1; end
        M_OP: begin
          if (held_char == "!") k = K_NOT;
          else if (held_char == "=") k = K_ASSIGN;
          else if (held_char == "<") k = K_LT;
          else if (held_char == ">") k = K_GT;
          else k = K_BADCHAR;
          slot[n] = mk_tok(k, sline, scol, 16'd1); n = n + 2'd1;
        end
        default: ;
      endcase
      mode_next = M_IDLE;
      held_dot_next = 1'b0;
    end

    // lex the byte from idle
    if (do_begin) begin
      mode_next = M_IDLE;
      k = K_END;
      if (c == " " || c == "\t" || c == "\r" || c == "\n") begin
        k = K_END;
      end else if (dig || alp || c == "$" || c == "\"" || c == "'" || c == "#" ||
                   c == "/" || c == "!" || c == "=" || c == "<" || c == ">" ||
                   c == "&" || c == "|") begin
        sline_next = lcnt;
        scol_next = ccnt;
        rlen_next = 16'd1;
        if (dig) begin
          mode_next = M_NUM;
          acc_next = {59'd0, c[3:0]};
          ovf_next = 1'b0;
        end else if (alp || c == "$") begin
          mode_next = M_IDENT;
          wbuf_next = {56'd0, c};
          wlong_next = 1'b0;
        end else if (c == "\"" || c == "'") begin
          mode_next = M_STR;
          cq_next = (c == "'");
          esc_next = 1'b0;
        end else if (c == "#") mode_next = M_DIR;
        else if (c == "/") mode_next = M_SLASH;
        else begin
          mode_next = M_OP;
          held_char_next = c;
        end
      end else begin
        unique case (c)
          "(": k = K_LPAREN;
          ")": k = K_RPAREN;
          "{": k = K_LBRACE;
          "}": k = K_RBRACE;
          "[": k = K_LBRACK;
          "]": k = K_RBRACK;
          ",": k = K_COMMA;
          ".": k = K_DOT;
          ":": k = K_COLON;
          ";": k = K_SEMI;
          "+": k = K_PLUS;
          "-": k = K_MINUS;
          "*": k = K_STAR;
          "%": k = K_PCT;
          default: k = K_BADCHAR;
        endcase
        slot[n] = mk_tok(k, lcnt, ccnt, 16'd1); n = n + 2'd1;
      end
    end

    if (src_data.cmd == CMD_END) begin
      slot[n] = mk_tok(K_END, lcnt, ccnt, 16'd0); n = n + 2'd1;
      mode_next = M_IDLE; held_char_next = '0; held_dot_next = 1'b0;
      sline_next = LINE_WIDTH'(1); scol_next = COLUMN_WIDTH'(1); rlen_next = '0;
      lcnt_next = LINE_WIDTH'(1); ccnt_next = COLUMN_WIDTH'(1);
      acc_next = '0; ovf_next = 1'b0;
      wbuf_next = '0; wlong_next = 1'b0; cq_next = 1'b0; esc_next = 1'b0;
    end else if (c == "\n") begin
      if (lcnt != LINE_SAT) lcnt_next = lcnt + LINE_WIDTH'(1);
      ccnt_next = COLUMN_WIDTH'(1);
    end else if (ccnt != COL_SAT) begin
      ccnt_next = ccnt + COLUMN_WIDTH'(1);
    end

    if (n != 2'd0) slot[n - 2'd1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; held_char <= '0; held_dot <= 1'b0;
      sline <= LINE_WIDTH'(1); scol <= COLUMN_WIDTH'(1); rlen <= '0;
      lcnt <= LINE_WIDTH'(1); ccnt <= COLUMN_WIDTH'(1);
      acc <= '0; ovf <= 1'b0; wbuf <= '0; wlong <= 1'b0;
      cq <= 1'b0; esc <= 1'b0;
      cnt <= 2'd0; rd <= 2'd0;
    end else begin
      if (in_xfer) begin
        mode <= mode_next; held_char <= held_char_next;
        held_dot <= held_dot_next; sline <= sline_next; scol <= scol_next;
        rlen <= rlen_next; lcnt <= lcnt_next; ccnt <= ccnt_next;
        acc <= acc_next; ovf <= ovf_next; wbuf <= wbuf_next;
        wlong <= wlong_next; cq <= cq_next; esc <= esc_next;
        cnt <= n; rd <= 2'd0;
      end else if (out_xfer) begin
        cnt <= cnt - 2'd1;
        rd <= rd + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) res[i] <= slot[i];
    end
  end

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && src_data.cmd == CMD_END) |=>
      (mode == M_IDLE && lcnt == LINE_WIDTH'(1) && ccnt == COLUMN_WIDTH'(1)))
    else $error("state not cleared after end of source");
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && src_data.cmd == CMD_END) |=> tok_valid)
    else $error("end of source produced no token");
`endif

endmodule

[dv/script_token_lexer_tb.sv]
// Testbench for script_token_lexer: drives source bytes and end markers with
// random idling, predicts the token stream in a local lexer model and checks it.
// Depends on stl_pkg and the script_token_lexer RTL.
`timescale 1ns / 1ps
module script_token_lexer_tb;
  import stl_pkg::*;

  localparam logic [62:0] VAL_MAX = '1;
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
  localparam logic [COLUMN_WIDTH-1:0] COL_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  src_item_t src_data = '0;
  logic tok_valid;
  logic tok_stall = 1'b0;
  tok_item_t tok_data;

  script_token_lexer dut (.*);

  always #4 clk = ~clk;

  // lexer state mirror
  lex_mode_t lx_mode;
  logic [7:0] lx_held;
  logic lx_dot;
  logic [LINE_WIDTH-1:0] lx_sline, lx_line;
  logic [COLUMN_WIDTH-1:0] lx_scol, lx_col;
  logic [15:0] lx_len;
  logic [62:0] lx_acc;
  logic lx_ovf;
  logic [63:0] lx_word;
  logic lx_long, lx_squote, lx_esc;

  tok_item_t tokens_due[$];
  tok_item_t step_toks[$];
  int errors = 0;
  int sent = 0;
  bit quiet = 0;
  bit stream_done = 0;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic [15:0] bump(logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  task automatic push_tok(logic [5:0] k, logic [LINE_WIDTH-1:0] ln,
                          logic [COLUMN_WIDTH-1:0] cl, logic [15:0] len,
                          logic [62:0] iv = '0, logic ov = 1'b0, logic bv = 1'b0,
                          logic [7:0] sb = '0);
    tok_item_t t;
    t = '0;
    t.token_kind = k; t.token_line = ln; t.token_column = cl;
    t.token_length = len; t.num_value = iv; t.int_overflow = ov;
    t.true_flag = bv; t.string_byte = sb;
    if (step_toks.size() < 3) step_toks = {step_toks, t};
  endtask

  task automatic lex_clear();
    lx_mode = M_IDLE; lx_held = '0; lx_dot = 1'b0;
    lx_sline = LINE_WIDTH'(1); lx_scol = COLUMN_WIDTH'(1);
    lx_len = '0; lx_line = LINE_WIDTH'(1); lx_col = COLUMN_WIDTH'(1);
    lx_acc = '0; lx_ovf = 1'b0;
    lx_word = '0; lx_long = 1'b0; lx_squote = 1'b0; lx_esc = 1'b0;
  endtask

  function automatic logic [5:0] word_kind();
    logic [5:0] k;
    k = K_IDENT;
    if (!lx_long) begin
      case (lx_len)
        16'd2: if (lx_word == 64'("if")) k = K_IF;
               else if (lx_word == 64'("in")) k = K_IN;
        16'd3: if (lx_word == 64'("for")) k = K_FOR;
               else if (lx_word == 64'("try")) k = K_TRY;
        16'd4: if (lx_word == 64'("else")) k = K_ELSE;
               else if (lx_word == 64'("true")) k = K_TRUE;
               else if (lx_word == 64'("null")) k = K_NULL;
        16'd5: if (lx_word == 64'("while")) k = K_WHILE;
               else if (lx_word == 64'("until")) k = K_UNTIL;
               else if (lx_word == 64'("break")) k = K_BREAK;
               else if (lx_word == 64'("catch")) k = K_CATCH;
               else if (lx_word == 64'("false")) k = K_FALSE;
        16'd6: if (lx_word == 64'("repeat")) k = K_REPEAT;
               else if (lx_word == 64'("return")) k = K_RETURN;
        16'd7: if (lx_word == 64'("foreach") || lx_word == 64'("ForEach")) k = K_FOREACH;
               else if (lx_word == 64'("finally")) k = K_FINALLY;
        16'd8: if (lx_word == 64'("function")) k = K_FUNCTION;
               else if (lx_word == 64'("continue")) k = K_CONTINUE;
        default: ;
      endcase
    end
    return k;
  endfunction

  task automatic open_tok(lex_mode_t m);
    lx_mode = m; lx_sline = lx_line; lx_scol = lx_col; lx_len = 16'd1;
  endtask

  task automatic lex_start(logic [7:0] c);
    logic [5:0] k;
    lx_mode = M_IDLE;
    if (c == " " || c == 8'd9 || c == 8'd13 || c == 8'd10) return;
    if (is_dig(c)) begin
      open_tok(M_NUM); lx_acc = 63'(c - "0"); lx_ovf = 1'b0; return;
    end
    if (is_alp(c) || c == "$") begin
      open_tok(M_IDENT); lx_word = {56'd0, c}; lx_long = 1'b0; return;
    end
    if (c == "\"" || c == "'") begin
      open_tok(M_STR); lx_squote = (c == "'"); lx_esc = 1'b0; return;
    end
    case (c)
      "#": begin open_tok(M_DIR); return; end
      "/": begin open_tok(M_SLASH); return; end
      "!", "=", "<", ">", "&", "|": begin open_tok(M_OP); lx_held = c; return; end
      "(": k = K_LPAREN;  ")": k = K_RPAREN;  "{": k = K_LBRACE;
      "}": k = K_RBRACE;  "[": k = K_LBRACK;  "]": k = K_RBRACK;
      ",": k = K_COMMA;   ".": k = K_DOT;     ":": k = K_COLON;
      ";": k = K_SEMI;    "+": k = K_PLUS;    "-": k = K_MINUS;
      "*": k = K_STAR;    "%": k = K_PCT;
      default: k = K_BADCHAR;
    endcase
    push_tok(k, lx_line, lx_col, 16'd1);
  endtask

  task automatic lex_flush();
    logic [5:0] k;
    case (lx_mode)
      M_NUM: push_tok(K_INT, lx_sline, lx_scol, lx_len, lx_acc, lx_ovf);
      M_NUMDOT: begin
        push_tok(K_INT, lx_sline, lx_scol, lx_len, lx_acc, lx_ovf);
        push_tok(K_DOT, lx_line, (lx_col == COL_MAX || lx_col < COLUMN_WIDTH'(2)) ?
                 lx_col : lx_col - COLUMN_WIDTH'(1), 16'd1);
      end
      M_FRAC: push_tok(K_FRAC, lx_sline, lx_scol, lx_len);
      M_IDENT: begin
        k = word_kind();
        push_tok(k, lx_sline, lx_scol, lx_len, '0, 1'b0, k == K_TRUE);
      end
      M_DIR: push_tok(K_DIR, lx_sline, lx_scol, lx_len);
      M_STR: push_tok(K_UNTERM, lx_sline, lx_scol, lx_len);
      M_SLASH: push_tok(K_DIV, lx_sline, lx_scol, 16'd1);
      M_OP: begin
        case (lx_held)
          "!": k = K_NOT;  "=": k = K_ASSIGN;
          "<": k = K_LT;   ">": k = K_GT;
          default: k = K_BADCHAR;
        endcase
        push_tok(k, lx_sline, lx_scol, 16'd1);
      end
      default: ;
    endcase
    lx_mode = M_IDLE; lx_dot = 1'b0;
  endtask

  task automatic lex_char(logic [7:0] c);
    logic [5:0] k;
    logic [62:0] d;
    logic [7:0] v;
    case (lx_mode)
      M_NUM:
        if (is_dig(c)) begin
          d = 63'(c - "0");
          lx_len = bump(lx_len);
          if (!lx_ovf) begin
            if (lx_acc > (VAL_MAX - d) / 63'd10) begin
              lx_ovf = 1'b1; lx_acc = VAL_MAX;
            end else lx_acc = lx_acc * 63'd10 + d;
          end
        end else if (c == ".") begin
          lx_mode = M_NUMDOT; lx_dot = 1'b1;
        end else begin lex_flush(); lex_start(c); end
      M_NUMDOT:
        if (is_dig(c)) begin
          lx_mode = M_FRAC; lx_dot = 1'b0; lx_len = bump(bump(lx_len));
        end else begin lex_flush(); lex_start(c); end
      M_FRAC:
        if (is_dig(c)) lx_len = bump(lx_len);
        else begin lex_flush(); lex_start(c); end
      M_IDENT:
        if (is_alp(c) || is_dig(c) || c == "_") begin
          if (lx_len >= 16'(KEYWORD_MAX_CHARS)) lx_long = 1'b1;
          else lx_word = {lx_word[55:0], c};
          lx_len = bump(lx_len);
        end else begin lex_flush(); lex_start(c); end
      M_DIR:
        if (is_alp(c)) lx_len = bump(lx_len);
        else begin lex_flush(); lex_start(c); end
      M_STR: begin
        lx_len = bump(lx_len);
        if (lx_esc) begin
          v = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : (c == "r") ? 8'd13 : c;
          lx_esc = 1'b0;
          push_tok(K_SCHAR, lx_sline, lx_scol, 16'd0, '0, 1'b0, 1'b0, v);
        end else if (c == (lx_squote ? "'" : "\"")) begin
          push_tok(K_STR, lx_sline, lx_scol, lx_len);
          lx_mode = M_IDLE;
        end else if (c == "\\") lx_esc = 1'b1;
        else push_tok(K_SCHAR, lx_sline, lx_scol, 16'd0, '0, 1'b0, 1'b0, c);
      end
      M_SLASH:
        if (c == "/") lx_mode = M_LCOM;
        else if (c == "*") begin lx_mode = M_BCOM; lx_dot = 1'b0; end
        else begin lex_flush(); lex_start(c); end
      M_LCOM: if (c == 8'd10) lx_mode = M_IDLE;
      M_BCOM:
        if (lx_dot && c == "/") begin lx_mode = M_IDLE; lx_dot = 1'b0; end
        else lx_dot = (c == "*");
      M_OP: begin
        k = '0;
        if (c == "=") begin
          if (lx_held == "!") k = K_NE;
          else if (lx_held == "=") k = K_EQ;
          else if (lx_held == "<") k = K_LE;
          else if (lx_held == ">") k = K_GE;
        end else if (c == "&" && lx_held == "&") k = K_AND;
        else if (c == "|" && lx_held == "|") k = K_OR;
        if (k != 6'd0) begin
          push_tok(k, lx_sline, lx_scol, 16'd2); lx_mode = M_IDLE;
        end else begin lex_flush(); lex_start(c); end
      end
      default: lex_start(c);
    endcase
  endtask

  task automatic lex_predict(src_item_t it);
    tok_item_t t;
    step_toks.delete();
    if (it.cmd == CMD_END) begin
      lex_flush();
      push_tok(K_END, lx_line, lx_col, 16'd0);
      lex_clear();
    end else begin
      lex_char(it.ch);
      if (it.ch == 8'd10) begin
        if (lx_line != LINE_MAX) lx_line++;
        lx_col = COLUMN_WIDTH'(1);
      end else if (lx_col != COL_MAX) lx_col++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_of_run = 1'b1;
    foreach (step_toks[i]) begin
      t = step_toks[i];
      tokens_due = {tokens_due, t};
    end
  endtask

  // result checking
  always @(posedge clk) begin
    tok_item_t e;
    if (!rst && tok_valid && !tok_stall) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual %p", $time, tok_data);
        errors++;
      end else begin
        e = tokens_due.pop_front();
        if (tok_data !== e) begin
          $display("%0t: token mismatch, expected %p, actual %p", $time, e, tok_data);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    @(negedge clk);
    while (!stream_done) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        tok_stall <= 1'b1;
        repeat (n) @(negedge clk);
        tok_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  // valid stays high from one transfer to the next unless an idle burst comes
  task automatic send(src_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    lex_predict(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    src_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.cmd = CMD_CHAR; it.ch = s[i];
      send(it);
    end
  endtask

  task automatic send_end();
    src_item_t it;
    it.cmd = CMD_END; it.ch = 8'($urandom);
    send(it);
  endtask

  typedef struct {
    src_item_t in;
    bit        known;
    logic [5:0] kind;
  } row_t;

  string frags[] = '{"foreach ", "ForEach(", "continue;", "finally{", "function ",
    "if ", "else ", "while ", "for ", "repeat ", "until ", "return ", "break ",
    "try ", "catch ", "in ", "true,", "false ", "null ", "$x_9 ", "abcdefghij ",
    "9223372036854775807 ", "99999999999999999999 ", "3.14 ", "7.x ", "12.",
    "\"a\\nb\\tc\\r\\\"\" ", "'q\\'z' ", "#define ", "// cmt\n", "/* a * b **/",
    "/*/ x */", "/ ", "!= ", "! ", "== ", "= ", "<= ", "< ", ">= ", "> ", "&& ",
    "|| ", "& ", "| ", "()", "{}[]", ",.:;", "+-*%", "\n", "\t\r ", "\"open"};

  row_t rows[$];
  initial begin
    src_item_t it;
    row_t r;
    lex_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: kinds typed for single-result rows from idle
    r.in = '{cmd: CMD_END, ch: 8'h00}; r.known = 1; r.kind = K_END; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: 8'hFF}; r.known = 1; r.kind = K_BADCHAR; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: 8'h80}; r.known = 1; r.kind = K_BADCHAR; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: 8'h00}; r.known = 1; r.kind = K_BADCHAR; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "("}; r.known = 1; r.kind = K_LPAREN; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "%"}; r.known = 1; r.kind = K_PCT; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "\""}; r.known = 0; r.kind = '0; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "7"}; r.known = 0; rows = {rows, r};
    r.in = '{cmd: CMD_END, ch: 8'hFF}; r.known = 0; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "1"}; r.known = 0; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "."}; r.known = 0; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "&"}; r.known = 0; rows = {rows, r};
    r.in = '{cmd: CMD_CHAR, ch: "&"}; r.known = 0; rows = {rows, r};
    r.in = '{cmd: CMD_END, ch: 8'h55}; r.known = 0; rows = {rows, r};
    foreach (rows[i]) begin
      send(rows[i].in);
      if (rows[i].known && tokens_due.size() > 0 &&
          tokens_due[tokens_due.size()-1].token_kind != rows[i].kind) begin
        $display("%0t: row %0d kind, expected %0d, actual %0d", $time, i, rows[i].kind,
                 tokens_due[tokens_due.size()-1].token_kind);
        errors++;
      end
    end

    // random: mostly well-formed fragments, some raw noise
    while (sent < 116) begin
      if (sent >= 92) quiet = 1;
      if ($urandom_range(0, 4) == 0) begin
        it.cmd = CMD_CHAR; it.ch = 8'($urandom);
        send(it);
      end else send_text(frags[$urandom_range(0, frags.size() - 1)]);
      if ($urandom_range(0, 5) == 0) send_end();
    end
    send_end();
    src_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    stream_done = 1;
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end
endmodule
